// ===== rtl/core/ttcg_pkg.sv =====
// Shared types and constants for the tap tempo clock generator.
`default_nettype none
package ttcg_pkg;

  // Fixed payload widths of the channels.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TOUT_W  = 16;
  localparam int unsigned TRAIL_W = 8;
  localparam int unsigned CIDX_W  = 8;
  localparam int unsigned CDATA_W = 32;

  // Tap counter width: history depth is at most three.
  localparam int unsigned CNT_W = 2;

  // Action codes of an input request.
  typedef enum logic {
    ACT_PRESS = 1'b0,
    ACT_TICK  = 1'b1
  } act_t;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    REG_INACT_TIMEOUT = 8'd0,
    REG_TRAIL_COUNT   = 8'd1
  } reg_idx_t;

  // Control and status state passed between the top level and the step logic.
  typedef struct packed {
    logic [CNT_W-1:0] tap_count;
    logic             flash_ok;
    logic             send_armed;
    logic             deadline_armed;
  } ctl_t;

endpackage : ttcg_pkg
`default_nettype wire

// ===== rtl/core/ttcg_if.sv =====
// Valid/ready channel interfaces for input, result and configuration requests.
`default_nettype none
interface ttcg_in_if
  import ttcg_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, output action, output time_ms, input ready);
  modport sink   (input valid, input action, input time_ms, output ready);
endinterface : ttcg_in_if

interface ttcg_out_if
  import ttcg_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              send_midi;
  logic              flash_valid;
  logic [TIME_W-1:0] flash_half_period;
  logic [TIME_W-1:0] beat_interval;

  modport source (output valid, output send_midi, output flash_valid,
                  output flash_half_period, output beat_interval, input ready);
  modport sink   (input valid, input send_midi, input flash_valid,
                  input flash_half_period, input beat_interval, output ready);
endinterface : ttcg_out_if

interface ttcg_cfg_if
  import ttcg_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : ttcg_cfg_if
`default_nettype wire

// ===== rtl/core/ttcg_step.sv =====
// Next-state and result logic for one press or tick request.
`default_nettype none
module ttcg_step
  import ttcg_pkg::*;
#(
  parameter int unsigned TIME_BITS     = 32,
  parameter int unsigned HISTORY_DEPTH = 3
) (
  input  wire logic                 action,
  input  wire logic [TIME_BITS-1:0] t,
  input  wire logic [TOUT_W-1:0]    timeout,
  input  wire logic [TRAIL_W-1:0]   trail_cfg,
  input  wire ctl_t                 ctl_cur,
  input  wire logic [TIME_BITS-1:0] hist_cur [HISTORY_DEPTH],
  input  wire logic [TIME_BITS-1:0] interval_cur,
  input  wire logic [TIME_BITS-1:0] half_cur,
  input  wire logic [TIME_BITS-1:0] next_cur,
  input  wire logic [TIME_BITS-1:0] deadline_cur,
  input  wire logic [TRAIL_W-1:0]   trail_cur,
  output ctl_t                      ctl_nxt,
  output logic [TIME_BITS-1:0]      hist_nxt [HISTORY_DEPTH],
  output logic [TIME_BITS-1:0]      interval_nxt,
  output logic [TIME_BITS-1:0]      half_nxt,
  output logic [TIME_BITS-1:0]      next_nxt,
  output logic [TIME_BITS-1:0]      deadline_nxt,
  output logic [TRAIL_W-1:0]        trail_nxt,
  output logic                      send
);

  localparam int unsigned     IDX_W     = (HISTORY_DEPTH > 2) ? 2 : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] CNT_AVG2 = CNT_W'(3);   // two intervals: halve sum
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  // Wrapped time compare: a is at or after b.
  function automatic logic reached(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return ~d[TIME_BITS-1];
  endfunction

  // ---- press path ----
  logic [CNT_W-1:0]     last_cnt;
  logic [TIME_BITS-1:0] last_tap;
  logic                 wipe;
  logic [CNT_W-1:0]     c0;
  logic                 full0;
  logic [TIME_BITS-1:0] hist_p [HISTORY_DEPTH];
  logic [CNT_W-1:0]     cnt_p;
  logic [TIME_BITS-1:0] sum;
  logic [TIME_BITS-1:0] avg;
  logic [TIME_BITS-1:0] cand;

  assign last_cnt = ctl_cur.tap_count - CNT_W'(1);
  assign last_tap = hist_cur[last_cnt[IDX_W-1:0]];
  assign wipe     = (ctl_cur.tap_count != '0) &&
                    ((t - last_tap) >= TIME_BITS'(timeout));
  assign c0       = wipe ? '0 : ctl_cur.tap_count;
  assign full0    = (c0 == CNT_FULL);
  assign cnt_p    = full0 ? c0 : c0 + CNT_W'(1);

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_hist
    if (i == HISTORY_DEPTH - 1) begin : g_top
      assign hist_p[i] = (full0 || (c0 == CNT_W'(i))) ? t : hist_cur[i];
    end else begin : g_low
      assign hist_p[i] = full0 ? hist_cur[i+1] :
                         ((c0 == CNT_W'(i)) ? t : hist_cur[i]);
    end
  end

  // Sum of wrapped intervals telescopes to newest minus oldest.
  assign sum  = t - hist_p[0];
  assign avg  = (cnt_p == CNT_AVG2) ? (sum >> 1) : sum;
  assign cand = t + ((avg != '0) ? avg : TIME_BITS'(1));

  // ---- tick path ----
  logic                 dl_hit;
  logic                 dl_armed_t;
  logic [TRAIL_W-1:0]   trail_t;
  logic [TRAIL_W-1:0]   trail_dec;
  logic                 due;

  assign dl_hit     = ctl_cur.deadline_armed && reached(t, deadline_cur);
  assign dl_armed_t = ctl_cur.deadline_armed && !dl_hit;
  assign trail_t    = dl_hit ? trail_cfg : trail_cur;
  assign trail_dec  = trail_t - TRAIL_W'(1);
  assign due        = reached(t, next_cur);

  always_comb begin
    ctl_nxt      = ctl_cur;
    hist_nxt     = hist_cur;
    interval_nxt = interval_cur;
    half_nxt     = half_cur;
    next_nxt     = next_cur;
    deadline_nxt = deadline_cur;
    trail_nxt    = trail_cur;
    send         = 1'b0;
    case (act_t'(action))
      ACT_PRESS: begin
        ctl_nxt.tap_count = cnt_p;
        hist_nxt          = hist_p;
        if (cnt_p >= CNT_TWO) begin
          interval_nxt     = (avg != '0) ? avg : TIME_BITS'(1);
          half_nxt         = (avg > TIME_BITS'(1)) ? (avg >> 1) : TIME_BITS'(1);
          ctl_nxt.flash_ok = 1'b1;
        end else begin
          interval_nxt     = '0;
          half_nxt         = '0;
          ctl_nxt.flash_ok = 1'b0;
        end
        trail_nxt = '0;
        if (cnt_p == CNT_FULL) begin
          // keep an earlier pending send if it comes first
          if (!ctl_cur.send_armed || !reached(cand, next_cur)) begin
            next_nxt = cand;
          end
          ctl_nxt.send_armed     = 1'b1;
          deadline_nxt           = t + TIME_BITS'(timeout);
          ctl_nxt.deadline_armed = 1'b1;
        end else begin
          ctl_nxt.send_armed     = 1'b0;
          ctl_nxt.deadline_armed = 1'b0;
        end
      end
      ACT_TICK: begin
        if (ctl_cur.send_armed) begin
          ctl_nxt.deadline_armed = dl_armed_t;
          trail_nxt              = trail_t;
          if (due) begin
            send     = 1'b1;
            next_nxt = next_cur + interval_cur;
            if (!dl_armed_t && (trail_t != '0)) begin
              trail_nxt = trail_dec;
              if (trail_dec == '0) begin
                ctl_nxt.send_armed = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        send = 1'b0;
      end
    endcase
  end

endmodule : ttcg_step
`default_nettype wire

// ===== rtl/core/tap_tempo_clock_generator_unit.sv =====
// Tap tempo clock generator: request registers, tempo state and result register.
// Each request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the result channel is not stalled.
// A stalled result holds in the output register while one more request waits.
// Reset (rst_n low, synchronous): timeout 2000 ms, trailing count 4, tap count and
// tempo state cleared (history, send time and deadline are not reset), both channels empty.
`default_nettype none
module tap_tempo_clock_generator_unit
  import ttcg_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 3,
  parameter int unsigned TIME_BITS     = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ttcg_in_if.sink     in_ch,
  ttcg_out_if.source  out_ch,
  ttcg_cfg_if.sink    cfg_ch
);

  localparam int unsigned  W        = TIME_BITS;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land at any time; the user must issue them only
  // while the block is idle, to avoid a hazard with requests in flight; not enforced here.
  // ---------------------------------------------------------------------------
  logic [TOUT_W-1:0]  timeout_r;
  logic [TRAIL_W-1:0] trail_cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TOUT_W'(2000);
      trail_cfg_r <= TRAIL_W'(4);
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_INACT_TIMEOUT: timeout_r   <= cfg_ch.data[TOUT_W-1:0];
        REG_TRAIL_COUNT:   trail_cfg_r <= cfg_ch.data[TRAIL_W-1:0];
        default: begin
          // unknown index: dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register (stage 1). Advances into the state/result stage whenever
  // the result register is empty or being drained.
  // ---------------------------------------------------------------------------
  logic         s1_valid_r;
  logic         s1_action_r;
  logic [W-1:0] s1_time_r;
  logic         adv;
  logic         out_valid_r;

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_action_r <= in_ch.action;
      s1_time_r   <= in_ch.time_ms[W-1:0];   // only the low TIME_BITS wrap
    end
  end

  // ---------------------------------------------------------------------------
  // Tempo state. History, send time and deadline are payload: they are only
  // read below the tap count or while their armed flag is set.
  // ---------------------------------------------------------------------------
  ctl_t               ctl_r;
  ctl_t               ctl_nxt;
  logic [W-1:0]       hist_r       [HISTORY_DEPTH];
  logic [W-1:0]       hist_nxt     [HISTORY_DEPTH];
  logic [W-1:0]       interval_r;
  logic [W-1:0]       interval_nxt;
  logic [W-1:0]       half_r;
  logic [W-1:0]       half_nxt;
  logic [W-1:0]       next_send_r;
  logic [W-1:0]       next_send_nxt;
  logic [W-1:0]       deadline_r;
  logic [W-1:0]       deadline_nxt;
  logic [TRAIL_W-1:0] trail_left_r;
  logic [TRAIL_W-1:0] trail_left_nxt;
  logic               send_nxt;

  ttcg_step #(
    .TIME_BITS     (TIME_BITS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_step (
    .action       (s1_action_r),
    .t            (s1_time_r),
    .timeout      (timeout_r),
    .trail_cfg    (trail_cfg_r),
    .ctl_cur      (ctl_r),
    .hist_cur     (hist_r),
    .interval_cur (interval_r),
    .half_cur     (half_r),
    .next_cur     (next_send_r),
    .deadline_cur (deadline_r),
    .trail_cur    (trail_left_r),
    .ctl_nxt      (ctl_nxt),
    .hist_nxt     (hist_nxt),
    .interval_nxt (interval_nxt),
    .half_nxt     (half_nxt),
    .next_nxt     (next_send_nxt),
    .deadline_nxt (deadline_nxt),
    .trail_nxt    (trail_left_nxt),
    .send         (send_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r        <= '0;
      interval_r   <= '0;
      half_r       <= '0;
      trail_left_r <= '0;
    end else if (adv) begin
      ctl_r        <= ctl_nxt;
      interval_r   <= interval_nxt;
      half_r       <= half_nxt;
      trail_left_r <= trail_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hist_r      <= hist_nxt;
      next_send_r <= next_send_nxt;
      deadline_r  <= deadline_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. The fields show the state left by the request.
  // ---------------------------------------------------------------------------
  logic         res_send_r;
  logic         res_flash_r;
  logic [W-1:0] res_half_r;
  logic [W-1:0] res_interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_send_r     <= send_nxt;
      res_flash_r    <= ctl_nxt.flash_ok;
      res_half_r     <= half_nxt;
      res_interval_r <= interval_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.send_midi         = res_send_r;
  assign out_ch.flash_valid       = res_flash_r;
  assign out_ch.flash_half_period = TIME_W'(res_half_r);
  assign out_ch.beat_interval     = TIME_W'(res_interval_r);

`ifndef SYNTHESIS
  // A send needs a full history, so the flash interval is always present.
  a_send_has_flash: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_send_r) |-> res_flash_r)
    else $error("send flagged without a flash interval");

  // The tap count never runs past the history depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.tap_count <= CNT_FULL)
    else $error("tap count beyond history depth");

  // Sending is armed only with a full history.
  a_armed_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.send_armed |-> (ctl_r.tap_count == CNT_FULL))
    else $error("send armed with partial history");

  // The inactivity deadline is only pending while sending is armed.
  a_deadline_armed: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.deadline_armed |-> ctl_r.send_armed)
    else $error("deadline armed while sending is off");
`endif

endmodule : tap_tempo_clock_generator_unit
`default_nettype wire
